// ===== rtl/core/tfrc_pkg.sv =====
package tfrc_pkg;

  localparam int REG_COUNT = 4;
  localparam int REG_IDX_W = 2;
  localparam int PC_W      = 8;
  localparam int INSTR_W   = 16;
  localparam int READ_W    = 32;
  localparam int PRINT_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int OP_W      = 4;
  localparam int IMM_W     = 8;

  localparam logic [OP_W-1:0] OP_ADDI  = 4'd0;
  localparam logic [OP_W-1:0] OP_BLT   = 4'd1;
  localparam logic [OP_W-1:0] OP_BNE   = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd3;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd4;
  localparam logic [OP_W-1:0] OP_READ  = 4'd5;
  localparam logic [OP_W-1:0] OP_PRINT = 4'd6;
  localparam logic [OP_W-1:0] OP_J     = 4'd7;

  localparam logic [STATUS_W-1:0] ST_RUN      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FIN      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_JUMP = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_OP   = 2'd3;

  localparam logic [PC_W-1:0] PROG_LEN_RESET = 8'd1;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    logic                 we;
    logic [REG_IDX_W-1:0] idx;
  } wb_ctl_t;

endpackage

// ===== rtl/core/tfrc_if.sv =====
interface tfrc_in_if;
  logic                               valid;
  logic                               ready;
  logic [tfrc_pkg::INSTR_W-1:0]       instr_word;
  logic signed [tfrc_pkg::READ_W-1:0] read_value;

  modport source (output valid, output instr_word, output read_value, input ready);
  modport sink (input valid, input instr_word, input read_value, output ready);
endinterface

interface tfrc_out_if;
  logic                                valid;
  logic                                ready;
  logic [tfrc_pkg::PC_W-1:0]           next_pc;
  logic                                print_valid;
  logic signed [tfrc_pkg::PRINT_W-1:0] print_value;
  logic [tfrc_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output next_pc, output print_valid, output print_value,
                  output status, input ready);
  modport sink (input valid, input next_pc, input print_valid, input print_value,
                input status, output ready);
endinterface

interface tfrc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [tfrc_pkg::PC_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tfrc_regfile.sv =====
module tfrc_regfile #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  tfrc_pkg::wb_ctl_t                                     wb,
  input  logic [DATA_WIDTH-1:0]                                 wb_data,
  output logic [tfrc_pkg::REG_COUNT-1:0][DATA_WIDTH-1:0]        regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wb.we) begin
      regs[wb.idx] <= wb_data;
    end
  end

endmodule

// ===== rtl/core/tfrc_alu.sv =====
module tfrc_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  logic [tfrc_pkg::REG_COUNT-1:0][DATA_WIDTH-1:0] regs,
  input  tfrc_pkg::pc_t                                  pc,
  input  tfrc_pkg::pc_t                                  prog_len,
  input  logic [tfrc_pkg::INSTR_W-1:0]                   instr_word,
  input  logic signed [tfrc_pkg::READ_W-1:0]             read_value,
  output tfrc_pkg::wb_ctl_t                              wb,
  output logic [DATA_WIDTH-1:0]                          wb_data,
  output tfrc_pkg::pc_t                                  next_pc,
  output logic                                           print_valid,
  output logic signed [tfrc_pkg::PRINT_W-1:0]            print_value,
  output logic [tfrc_pkg::STATUS_W-1:0]                  status
);

  logic [tfrc_pkg::OP_W-1:0]      op;
  logic [tfrc_pkg::REG_IDX_W-1:0] ra;
  logic [tfrc_pkg::REG_IDX_W-1:0] rb;
  logic [tfrc_pkg::REG_IDX_W-1:0] rc;
  logic [tfrc_pkg::IMM_W-1:0]     imm8;
  logic [DATA_WIDTH-1:0]          imm;
  logic [DATA_WIDTH-1:0]          a;
  logic [DATA_WIDTH-1:0]          b;
  logic [DATA_WIDTH-1:0]          c;
  logic [DATA_WIDTH-1:0]          prod;
  logic                           halted;
  logic                           jump;
  logic                           bad_op;
  logic                           we;

  assign op   = instr_word[15:12];
  assign ra   = instr_word[11:10];
  assign rb   = instr_word[9:8];
  assign rc   = instr_word[7:6];
  assign imm8 = instr_word[7:0];
  assign imm  = DATA_WIDTH'($signed(imm8));
  assign a    = regs[ra];
  assign b    = regs[rb];
  assign c    = regs[rc];
  assign prod = b * c;

  assign halted = (pc >= prog_len);

  always_comb begin
    jump        = 1'b0;
    bad_op      = 1'b0;
    we          = 1'b0;
    wb_data     = '0;
    print_valid = 1'b0;
    print_value = '0;
    case (op)
      tfrc_pkg::OP_ADDI: begin
        we      = 1'b1;
        wb_data = b + imm;
      end
      tfrc_pkg::OP_BLT: begin
        jump = ($signed(a) < $signed(b));
      end
      tfrc_pkg::OP_BNE: begin
        jump = (a != b);
      end
      tfrc_pkg::OP_MUL: begin
        we      = 1'b1;
        wb_data = prod;
      end
      tfrc_pkg::OP_SUB: begin
        we      = 1'b1;
        wb_data = b - c;
      end
      tfrc_pkg::OP_READ: begin
        we      = 1'b1;
        wb_data = DATA_WIDTH'(read_value);
      end
      tfrc_pkg::OP_PRINT: begin
        print_valid = 1'b1;
        print_value = tfrc_pkg::PRINT_W'($signed(a));
      end
      tfrc_pkg::OP_J: begin
        jump = 1'b1;
      end
      default: begin
        bad_op = 1'b1;
      end
    endcase

    if (halted) begin
      we          = 1'b0;
      print_valid = 1'b0;
      print_value = '0;
    end
  end

  always_comb begin
    next_pc = pc;
    status  = tfrc_pkg::ST_RUN;
    if (halted) begin
      status = (pc == prog_len) ? tfrc_pkg::ST_FIN : tfrc_pkg::ST_BAD_JUMP;
    end else if (bad_op) begin
      status = tfrc_pkg::ST_BAD_OP;
    end else begin
      if (jump) begin
        if (imm8[tfrc_pkg::IMM_W-1] || (imm8 > prog_len)) begin
          status = tfrc_pkg::ST_BAD_JUMP;
        end else begin
          next_pc = imm8;
        end
      end else begin
        next_pc = pc + 8'd1;
      end
      if ((status == tfrc_pkg::ST_RUN) && (next_pc == prog_len)) begin
        status = tfrc_pkg::ST_FIN;
      end
    end
  end

  assign wb.we  = we;
  assign wb.idx = ra;

endmodule

// ===== rtl/core/tiny_four_register_cpu_execute.sv =====
// Execute unit of a four-register toy CPU with 16-bit instructions.
// Channels:
//   instr  - one word per instruction fetched at the current pc, with the
//            value that a read instruction loads.
//   result - one word per instruction: next fetch address, print flag and
//            value, and status (running, finished, bad jump, bad opcode).
//   cfg    - write of the program length; write only while no instruction
//            is in flight.
// The input register loads when an instruction is accepted and the result
// register when that instruction executes, which a held result can delay.
// Throughput: one instruction per cycle unless a held result stalls it;
// the register file and pc are updated in the same cycle the instruction
// executes, so the next instruction sees the updated values.
// Reset: registers and pc clear to zero, program length to one, both
// pipeline stages empty.
// Stall: a held result keeps its register; one more instruction waits in the
// input register, then instr.ready drops until result.ready returns.
module tiny_four_register_cpu_execute #(
  parameter int DATA_WIDTH = 32
) (
  input logic         clk,
  input logic         rst,
  tfrc_in_if.sink     instr,
  tfrc_out_if.source  result,
  tfrc_cfg_if.sink    cfg
);

  logic                               s1_valid;
  logic [tfrc_pkg::INSTR_W-1:0]       s1_instr;
  logic signed [tfrc_pkg::READ_W-1:0] s1_read;
  logic                               out_load;
  logic                               s1_go;

  tfrc_pkg::pc_t pc;
  tfrc_pkg::pc_t prog_len;

  logic [tfrc_pkg::REG_COUNT-1:0][DATA_WIDTH-1:0] regs;

  tfrc_pkg::wb_ctl_t                   alu_wb;
  tfrc_pkg::wb_ctl_t                   wb;
  logic [DATA_WIDTH-1:0]               wb_data;
  tfrc_pkg::pc_t                       pc_next;
  logic                                print_valid_next;
  logic signed [tfrc_pkg::PRINT_W-1:0] print_value_next;
  logic [tfrc_pkg::STATUS_W-1:0]       status_next;

  assign out_load    = !result.valid || result.ready;
  assign s1_go       = s1_valid && out_load;
  assign instr.ready = !s1_valid || out_load;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (instr.ready) begin
      s1_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr.valid && instr.ready) begin
      s1_instr <= instr.instr_word;
      s1_read  <= instr.read_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prog_len <= tfrc_pkg::PROG_LEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      prog_len <= cfg.data;
    end
  end

  tfrc_alu #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_alu (
    .regs        (regs),
    .pc          (pc),
    .prog_len    (prog_len),
    .instr_word  (s1_instr),
    .read_value  (s1_read),
    .wb          (alu_wb),
    .wb_data     (wb_data),
    .next_pc     (pc_next),
    .print_valid (print_valid_next),
    .print_value (print_value_next),
    .status      (status_next)
  );

  assign wb.we  = alu_wb.we && s1_go;
  assign wb.idx = alu_wb.idx;

  tfrc_regfile #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .wb      (wb),
    .wb_data (wb_data),
    .regs    (regs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (s1_go) begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      result.next_pc     <= pc_next;
      result.print_valid <= print_valid_next;
      result.print_value <= print_value_next;
      result.status      <= status_next;
    end
  end

`ifndef SYNTHESIS
  a_pc_matches_result: assert property (@(posedge clk) disable iff (rst)
    s1_go |=> result.next_pc == pc)
    else $error("pc differs from reported next_pc");

  a_bad_op_holds_pc: assert property (@(posedge clk) disable iff (rst)
    s1_go && (status_next == tfrc_pkg::ST_BAD_OP) |=> pc == $past(pc))
    else $error("unknown opcode moved pc");

  a_no_write_when_blocked: assert property (@(posedge clk) disable iff (rst)
    wb.we |-> s1_go && (status_next != tfrc_pkg::ST_BAD_OP))
    else $error("register write without executing instruction");

  a_print_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.print_valid |-> result.print_value == '0)
    else $error("print value nonzero without print");
`endif

endmodule
